### design/jsd_pkg.sv
// Package with the shared types and codes of the JSON string decoder.
package jsd_pkg;

    // Result status codes.
    localparam logic [1:0] STATUS_CHAR   = 2'd0;
    localparam logic [1:0] STATUS_CLOSED = 2'd1;
    localparam logic [1:0] STATUS_REJECT = 2'd2;

    // Byte codes the decoder looks for.
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_TILDE  = 8'h7E;
    localparam logic [7:0] CHAR_LOW_B  = 8'h62;
    localparam logic [7:0] CHAR_LOW_F  = 8'h66;
    localparam logic [7:0] CHAR_LOW_N  = 8'h6E;
    localparam logic [7:0] CHAR_LOW_R  = 8'h72;
    localparam logic [7:0] CHAR_LOW_T  = 8'h74;
    localparam logic [7:0] CHAR_LOW_U  = 8'h75;

    // Largest value the first three hex digits of a unicode escape may hold,
    // so that the complete four-digit value stays at or below 127.
    localparam logic [11:0] HEX_MAX_HIGH = 12'd7;

    // One decode step's result toward the output register.
    typedef struct packed {
        logic       valid;
        logic [1:0] status;
        logic [6:0] char_out;
    } jsd_result_t;

endpackage

### design/jsd_if.sv
// Handshake interfaces for the byte input channel and the result channel.
interface jsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_data;

    modport source (output valid, output in_byte, output end_of_data, input ready);
    modport sink   (input valid, input in_byte, input end_of_data, output ready);
endinterface

interface jsd_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [6:0] char_out;

    modport source (output valid, output status, output char_out, input ready);
    modport sink   (input valid, input status, input char_out, output ready);
endinterface

### design/json_string_decoder_unit.sv
// Top level of the streaming JSON string decoder.
//
// The decoder takes one raw byte per item, skips leading space, tab, CR and
// LF, requires an opening double quote, and then delivers one result item
// per decoded character. Simple escapes and four-digit unicode escapes with
// a value from 1 to 127 are decoded. The string ends with a "closed" result
// at the closing quote, or with a "rejected" result on any malformed input,
// including data whose last byte comes before the closing quote. After
// either result the decoder is idle and waits for the next string. A
// consumer should discard characters already received for a string that is
// later rejected. Leading whitespace, the opening quote, a backslash, the
// u of a unicode escape and its first three hex digits produce no result
// item. The block takes one byte in every clock cycle when the result side
// keeps up: a byte is held in the input register, the decode step and the
// state update happen as it moves on, and the result is then held in the
// output register. The output register lets the next byte be decoded in
// the same cycle in which the previous result is taken; when the result
// side stalls, the input register holds one byte and input ready drops.
module json_string_decoder_unit
(
    input  logic          clk,
    input  logic          rst_n,
    jsd_byte_if.sink      data,
    jsd_result_if.source  result
);
    import jsd_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_status_reg;
    logic [6:0]  out_char_reg;

    logic        step;
    jsd_result_t step_result;

    // A held byte is decoded when the output register is free or emptying.
    assign step       = in_valid_reg && (!out_valid_reg || result.ready);
    assign data.ready = !in_valid_reg || step;

    jsd_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .in_byte     (in_byte_reg),
        .end_of_data (in_last_reg),
        .result      (step_result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = step_result.valid;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (data.ready)
                in_valid_reg <= data.valid;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (data.valid && data.ready)
        begin
            in_byte_reg <= data.in_byte;
            in_last_reg <= data.end_of_data;
        end
        if (step && step_result.valid)
        begin
            out_status_reg <= step_result.status;
            out_char_reg   <= step_result.char_out;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.status   = out_status_reg;
    assign result.char_out = out_char_reg;

endmodule

### design/jsd_core.sv
// Decoder state registers and the single-byte decode step.
module jsd_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          in_byte,
    input  logic                end_of_data,
    output jsd_pkg::jsd_result_t result
);
    import jsd_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_BODY = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_HEX  = 3'd3
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [11:0] hex_accum_reg, hex_accum_next;
    logic [1:0]  hex_count_reg, hex_count_next;

    logic        is_space;
    logic        hex_ok;
    logic [3:0]  hex_digit;
    logic        do_reject;
    logic        do_close;
    logic        do_emit;
    logic [6:0]  ch;
    logic [6:0]  hex_char;

    // Hex digit decode, either case.
    always_comb
    begin
        hex_ok    = 1'b1;
        hex_digit = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
            hex_digit = 4'(in_byte - 8'h30);
        else if (in_byte >= 8'h61 && in_byte <= 8'h66)
            hex_digit = 4'(in_byte - 8'h57);
        else if (in_byte >= 8'h41 && in_byte <= 8'h46)
            hex_digit = 4'(in_byte - 8'h37);
        else
            hex_ok = 1'b0;
    end

    assign is_space = (in_byte == CHAR_SPACE) || (in_byte == CHAR_TAB) ||
                      (in_byte == CHAR_CR) || (in_byte == CHAR_LF);
    assign hex_char = {hex_accum_reg[2:0], hex_digit};

    always_comb
    begin
        mode_next      = mode_reg;
        hex_accum_next = hex_accum_reg;
        hex_count_next = hex_count_reg;
        do_reject      = 1'b0;
        do_close       = 1'b0;
        do_emit        = 1'b0;
        ch             = 7'd0;

        unique case (mode_reg)
            MODE_IDLE:
            begin
                if (!is_space)
                begin
                    if (in_byte == CHAR_QUOTE)
                        mode_next = MODE_BODY;
                    else
                        do_reject = 1'b1;
                end
            end
            MODE_BODY:
            begin
                if (in_byte == CHAR_QUOTE)
                    do_close = 1'b1;
                else if (in_byte < CHAR_SPACE || in_byte > CHAR_TILDE)
                    do_reject = 1'b1;
                else if (in_byte == CHAR_BSLASH)
                    mode_next = MODE_ESC;
                else
                begin
                    ch      = in_byte[6:0];
                    do_emit = 1'b1;
                end
            end
            MODE_ESC:
            begin
                mode_next = MODE_BODY;
                do_emit   = 1'b1;
                case (in_byte) inside
                    CHAR_QUOTE, CHAR_BSLASH, CHAR_SLASH: ch = in_byte[6:0];
                    CHAR_LOW_B: ch = 7'd8;
                    CHAR_LOW_F: ch = 7'd12;
                    CHAR_LOW_N: ch = 7'd10;
                    CHAR_LOW_R: ch = 7'd13;
                    CHAR_LOW_T: ch = 7'd9;
                    CHAR_LOW_U:
                    begin
                        mode_next      = MODE_HEX;
                        hex_accum_next = 12'd0;
                        hex_count_next = 2'd0;
                        do_emit        = 1'b0;
                    end
                    default:
                    begin
                        do_reject = 1'b1;
                        do_emit   = 1'b0;
                    end
                endcase
            end
            MODE_HEX:
            begin
                if (!hex_ok)
                    do_reject = 1'b1;
                else if (hex_count_reg != 2'd3)
                begin
                    hex_accum_next = {hex_accum_reg[7:0], hex_digit};
                    hex_count_next = hex_count_reg + 2'd1;
                end
                else if (hex_accum_reg > HEX_MAX_HIGH || hex_char == 7'd0)
                    do_reject = 1'b1;
                else
                begin
                    ch             = hex_char;
                    do_emit        = 1'b1;
                    mode_next      = MODE_BODY;
                    hex_accum_next = 12'd0;
                    hex_count_next = 2'd0;
                end
            end
            default:
                do_reject = 1'b1;
        endcase

        // The last byte of the data rejects anything that did not close.
        if (end_of_data && !do_close)
            do_reject = 1'b1;

        result.valid    = do_reject || do_close || do_emit;
        result.status   = STATUS_CHAR;
        result.char_out = ch;
        if (do_reject)
        begin
            result.status   = STATUS_REJECT;
            result.char_out = 7'd0;
        end
        else if (do_close)
        begin
            result.status   = STATUS_CLOSED;
            result.char_out = 7'd0;
        end

        if (do_reject || do_close)
        begin
            mode_next      = MODE_IDLE;
            hex_accum_next = 12'd0;
            hex_count_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            hex_accum_reg <= 12'd0;
            hex_count_reg <= 2'd0;
        end
        else if (step)
        begin
            mode_reg      <= mode_next;
            hex_accum_reg <= hex_accum_next;
            hex_count_reg <= hex_count_next;
        end
    end

endmodule
